// ===== hw/rtl/stsf_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// stsf_pkg
// shared sizes and the controller state type for the subarray sum finder
// ---------------------------------------------------------------------------
package stsf_pkg;

	parameter int MAX_LEN     = 64;
	parameter int VALUE_W     = 16;
	parameter int PREFIX_W    = 23;
	parameter int RES_INDEX_W = 6;
	parameter int IDX_W       = $clog2(MAX_LEN);
	parameter int CNT_W       = $clog2(MAX_LEN + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_EMIT_RD,
		S_EMIT_WAIT,
		S_NOTFOUND
	} stsf_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/subarray_target_sum_finder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// subarray_target_sum_finder
// finds the earliest-ending contiguous subarray that sums to a target
// ---------------------------------------------------------------------------
// Elements arrive one item at a time, the final one flagged by end_of_sequence.
// Each stored element goes into the element ram, and its running prefix sum
// (23 bits, wrapping) into the prefix ram. The prefix ram is then scanned from
// the entry just below the newest one downwards, one read per cycle, for prefix - target_sum; the
// empty prefix (zero) counts as the oldest candidate. On the first hit the
// matching elements are read back from the element ram and sent out with
// found = 1, run_end on the last of them; later items of that sequence are
// swallowed. A sequence that ends without a hit yields a single result with
// found = 0 and run_end = 1. Elements past MAX_LEN are neither stored nor
// searched. The scan goes through the single prefix ram read port, and each
// result is read from the element ram in S_EMIT_RD and then held in
// S_EMIT_WAIT until the output is free. The next item is taken only once
// the block is back in idle; item_stall is high in every other state.
// target_sum may only be written while the block is idle.
// ---------------------------------------------------------------------------
module subarray_target_sum_finder
	import stsf_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// configuration
	input  wire logic                       cfg_write_en,
	input  wire logic signed [PREFIX_W-1:0] cfg_write_data,
	// element items
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire logic signed [VALUE_W-1:0]  element_value,
	input  wire logic                       end_of_sequence,
	// result items
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic signed [VALUE_W-1:0]       result_value,
	output logic        [RES_INDEX_W-1:0]   result_index,
	output logic                            found,
	output logic                            run_end
);

	stsf_state_t state_q, state_nxt;

	// sequence state
	logic [PREFIX_W-1:0] target_q;
	logic [PREFIX_W-1:0] running_q;
	logic [CNT_W-1:0]    count_q;
	logic                match_done_q;
	logic                last_q;

	// current element
	logic [IDX_W-1:0]    idx_q;
	logic [PREFIX_W-1:0] want_q;

	// scan pipeline: read issue then compare
	logic [IDX_W-1:0]    rd_cnt_q;
	logic                cmp_vld_s1;
	logic [IDX_W-1:0]    cmp_addr_s1;

	// emission pointer
	logic [IDX_W-1:0]    em_q;

	// output register
	logic                      res_valid_q;
	logic [VALUE_W-1:0]        res_value_q;
	logic [RES_INDEX_W-1:0]    res_index_q;
	logic                      res_found_q;
	logic                      res_end_q;

	logic                item_acc;
	logic                store_ok;
	logic [PREFIX_W-1:0] ev;
	logic [PREFIX_W-1:0] p_new;
	logic [PREFIX_W-1:0] want_new;
	logic [PREFIX_W-1:0] prefix_rd;
	logic [VALUE_W-1:0]  elem_rd;
	logic                hit;
	logic                scan_empty;
	logic                out_free;
	logic                load_res;
	logic                emit_last;
	logic                store_we;

	// input datapath
	assign item_acc  = item_valid && !item_stall;
	assign store_ok  = !match_done_q && (count_q < CNT_W'(MAX_LEN));
	assign store_we  = item_acc && store_ok;
	assign ev        = PREFIX_W'(element_value);
	assign p_new     = running_q + ev;
	assign want_new  = p_new - target_q;

	// scan and output handshake
	assign hit        = cmp_vld_s1 && (prefix_rd == want_q);
	assign scan_empty = (rd_cnt_q == '0) && !cmp_vld_s1;
	assign out_free   = !res_valid_q || !result_stall;
	assign emit_last  = (em_q == idx_q);
	assign load_res   = out_free && ((state_q == S_EMIT_WAIT) || (state_q == S_NOTFOUND));

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result_value = res_value_q;
	assign result_index = res_index_q;
	assign found        = res_found_q;
	assign run_end      = res_end_q;

	stsf_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_LEN)
	) u_elem_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (element_value),
		.raddr (em_q),
		.rdata (elem_rd)
	);

	// newest-first scan, address wraps harmlessly once the count is spent
	stsf_ram #(
		.WIDTH (PREFIX_W),
		.DEPTH (MAX_LEN)
	) u_prefix_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (p_new),
		.raddr (rd_cnt_q - IDX_W'(1)),
		.rdata (prefix_rd)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					if (store_ok) begin
						state_nxt = S_SEARCH;
					end else if (end_of_sequence && !match_done_q) begin
						state_nxt = S_NOTFOUND;
					end
				end
			end
			S_SEARCH: begin
				priority if (hit) begin
					state_nxt = S_EMIT_RD;
				end else if (scan_empty) begin
					// the empty prefix is the last candidate
					if (want_q == '0) begin
						state_nxt = S_EMIT_RD;
					end else if (last_q) begin
						state_nxt = S_NOTFOUND;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			S_EMIT_RD: begin
				state_nxt = S_EMIT_WAIT;
			end
			S_EMIT_WAIT: begin
				if (out_free) begin
					state_nxt = emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			S_NOTFOUND: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			target_q     <= '0;
			running_q    <= '0;
			count_q      <= '0;
			match_done_q <= 1'b0;
			last_q       <= 1'b0;
			rd_cnt_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg_write_en) begin
				target_q <= cfg_write_data;
			end

			if (item_acc) begin
				last_q <= end_of_sequence;
			end

			// store and start the scan
			if (store_we) begin
				running_q  <= p_new;
				count_q    <= count_q + CNT_W'(1);
				rd_cnt_q   <= count_q[IDX_W-1:0];
				cmp_vld_s1 <= 1'b0;
			end

			// items after a hit only close the sequence
			if (item_acc && !store_ok && end_of_sequence && match_done_q) begin
				running_q    <= '0;
				count_q      <= '0;
				match_done_q <= 1'b0;
			end

			if (state_q == S_SEARCH) begin
				cmp_vld_s1 <= (rd_cnt_q != '0) && !hit;
				if (rd_cnt_q != '0) begin
					rd_cnt_q <= rd_cnt_q - IDX_W'(1);
				end
				if (hit || (scan_empty && (want_q == '0))) begin
					match_done_q <= 1'b1;
				end
			end

			// the sequence closes on its last result
			if (load_res && (state_q == S_NOTFOUND || (emit_last && last_q))) begin
				running_q    <= '0;
				count_q      <= '0;
				match_done_q <= 1'b0;
			end

			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (store_we) begin
			idx_q  <= count_q[IDX_W-1:0];
			want_q <= want_new;
		end

		if (state_q == S_SEARCH) begin
			cmp_addr_s1 <= rd_cnt_q - IDX_W'(1);
			if (hit) begin
				em_q <= cmp_addr_s1 + IDX_W'(1);
			end else if (scan_empty) begin
				em_q <= '0;
			end
		end

		if (load_res) begin
			if (state_q == S_NOTFOUND) begin
				res_value_q <= '0;
				res_index_q <= '0;
				res_found_q <= 1'b0;
				res_end_q   <= 1'b1;
			end else begin
				res_value_q <= elem_rd;
				res_index_q <= RES_INDEX_W'(em_q);
				res_found_q <= 1'b1;
				res_end_q   <= emit_last;
				if (!emit_last) begin
					em_q <= em_q + IDX_W'(1);
				end
			end
		end
	end

	// fill count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_LEN))
		else $error("element count beyond store depth");

	// every compare looks at an entry older than the current element
	a_scan_older: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) && cmp_vld_s1 |-> (cmp_addr_s1 < idx_q))
		else $error("scan compared a non-older prefix");

	// a match is recorded only as emission starts
	a_match_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(match_done_q) |-> (state_q == S_EMIT_RD))
		else $error("match flagged without emission");

	// a not-found item always closes its sequence
	a_notfound_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_found_q |-> res_end_q && (res_index_q == '0))
		else $error("malformed not-found item");

	// emission never runs past the current element
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_WAIT) |-> (em_q <= idx_q))
		else $error("emission pointer past current element");

endmodule
`default_nettype wire

// ===== hw/rtl/stsf_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// stsf_ram
// simple dual-port synchronous ram, one write and one registered read port
// ---------------------------------------------------------------------------
module stsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
